@@ hdl/cursor_sequence_buffer_top_macros.svh @@
// ----------------------------------------------------------------------------
// cursor sequence buffer assertion macros
// shared concurrent assertion forms for the buffer rtl
// ----------------------------------------------------------------------------
`ifndef CURSOR_SEQUENCE_BUFFER_TOP_MACROS_SVH
`define CURSOR_SEQUENCE_BUFFER_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define CSB_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cursor sequence buffer check failed");

// next-cycle implication, checked out of reset
`define CSB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cursor sequence buffer check failed");

`endif

@@ hdl/cseqb_pkg.sv @@
// ----------------------------------------------------------------------------
// cseqb_pkg
// word types, command codes and cell control for the cursor sequence buffer
// ----------------------------------------------------------------------------
`default_nettype none

package cseqb_pkg;

  localparam int VALUE_W = 32;
  localparam int CMD_W   = 3;
  localparam int COUNT_W = 6;

  // command codes
  localparam logic [CMD_W-1:0] CMD_START   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADVANCE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ATTACH  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd4;

  // cell operations
  localparam logic [1:0] CELL_HOLD   = 2'd0;
  localparam logic [1:0] CELL_INSERT = 2'd1;
  localparam logic [1:0] CELL_REMOVE = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [VALUE_W-1:0] entry_value;
  } in_word_t;

  typedef struct packed {
    logic [VALUE_W-1:0] current_value;
    logic               has_current;
    logic [COUNT_W-1:0] item_count;
    logic               refused;
  } out_word_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [VALUE_W-1:0] value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ hdl/cseqb_cell.sv @@
// ----------------------------------------------------------------------------
// cseqb_cell
// one list slot: holds, loads, or takes the value of a neighbor
// ----------------------------------------------------------------------------
`default_nettype none

module cseqb_cell #(
  parameter int CELL_IDX = 0,
  parameter int CNT_W    = 6
) (
  input  wire logic                         clk,
  input  wire cseqb_pkg::cell_ctrl_t        ctrl,
  input  wire logic [CNT_W-1:0]             pos,
  input  wire logic [cseqb_pkg::VALUE_W-1:0] left_q,
  input  wire logic [cseqb_pkg::VALUE_W-1:0] right_q,
  output logic      [cseqb_pkg::VALUE_W-1:0] q
);

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(CELL_IDX);

  logic [cseqb_pkg::VALUE_W-1:0] q_r;
  logic [cseqb_pkg::VALUE_W-1:0] q_nxt;

  always_comb begin
    q_nxt = q_r;
    case (ctrl.op)
      cseqb_pkg::CELL_INSERT: begin
        // slot at the gap takes the new value, slots behind it move back
        if (IDX_C == pos) begin
          q_nxt = ctrl.value;
        end else if (IDX_C > pos) begin
          q_nxt = left_q;
        end
      end
      cseqb_pkg::CELL_REMOVE: begin
        // close the gap from behind
        if (IDX_C >= pos) begin
          q_nxt = right_q;
        end
      end
      default: q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

`default_nettype wire

@@ hdl/cursor_sequence_buffer_top.sv @@
// ----------------------------------------------------------------------------
// cursor_sequence_buffer_top
// bounded ordered list with a cursor, built as a row of shifting cells
// ----------------------------------------------------------------------------
// Each input word carries one command (start, advance, insert before, attach
// after, remove current) and yields exactly one result word with the value at
// the cursor, a current-entry flag, the entry count and a refusal flag. A
// command is one row update: the whole row of DEPTH cells shifts in the
// same edge that the word is accepted, so a new word is taken every cycle as
// long as the result register is empty or being drained. The result register
// separates the two sides, so in_ready only drops while a result waits and
// out_ready is low. The stored values have no reset; the count and cursor do.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cursor_sequence_buffer_top_macros.svh"

module cursor_sequence_buffer_top #(
  parameter int DEPTH = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire cseqb_pkg::in_word_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output cseqb_pkg::out_word_t      out_data
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

  // list control state
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [CNT_W-1:0] cursor_r;
  logic [CNT_W-1:0] cursor_nxt;

  // result register
  logic                 out_valid_r;
  cseqb_pkg::out_word_t out_word_r;
  cseqb_pkg::out_word_t out_word_nxt;

  // cell row
  logic [cseqb_pkg::VALUE_W-1:0] cell_q [DEPTH];
  cseqb_pkg::cell_ctrl_t         cell_ctrl;
  logic [CNT_W-1:0]              cell_pos;

  logic             accept;
  logic             has_cur;
  logic             full;
  logic             refused;
  logic             placed;      // new value becomes current this word
  logic             has_nxt;
  logic [CNT_W-1:0] rd_idx;      // slot, in the old row, that becomes current

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign has_cur  = cursor_r < count_r;
  assign full     = count_r >= DEPTH_C;

  // command decode; the row only moves on an accepted word
  always_comb begin
    count_nxt      = count_r;
    cursor_nxt     = cursor_r;
    refused        = 1'b0;
    placed         = 1'b0;
    rd_idx         = cursor_r;
    cell_pos       = cursor_r;
    cell_ctrl.op   = cseqb_pkg::CELL_HOLD;
    cell_ctrl.value = in_data.entry_value;
    unique case (in_data.cmd)
      cseqb_pkg::CMD_START: begin
        cursor_nxt = '0;
        rd_idx     = '0;
      end
      cseqb_pkg::CMD_ADVANCE: begin
        if (has_cur) begin
          cursor_nxt = cursor_r + ONE_C;
          rd_idx     = cursor_r + ONE_C;
        end else begin
          refused = 1'b1;
        end
      end
      cseqb_pkg::CMD_INSERT: begin
        if (full) begin
          refused = 1'b1;
        end else begin
          // no current entry: goes to the front
          cell_pos     = has_cur ? cursor_r : '0;
          cursor_nxt   = cell_pos;
          count_nxt    = count_r + ONE_C;
          placed       = 1'b1;
          cell_ctrl.op = cseqb_pkg::CELL_INSERT;
        end
      end
      cseqb_pkg::CMD_ATTACH: begin
        if (full) begin
          refused = 1'b1;
        end else begin
          // no current entry: appended at the end
          cell_pos     = has_cur ? (cursor_r + ONE_C) : count_r;
          cursor_nxt   = cell_pos;
          count_nxt    = count_r + ONE_C;
          placed       = 1'b1;
          cell_ctrl.op = cseqb_pkg::CELL_INSERT;
        end
      end
      cseqb_pkg::CMD_REMOVE: begin
        if (has_cur) begin
          // follower slides into the cursor slot
          count_nxt    = count_r - ONE_C;
          rd_idx       = cursor_r + ONE_C;
          cell_ctrl.op = cseqb_pkg::CELL_REMOVE;
        end else begin
          refused = 1'b1;
        end
      end
      default: begin
        // unknown command: no change, not refused
      end
    endcase
    if (!accept) begin
      cell_ctrl.op = cseqb_pkg::CELL_HOLD;
    end
  end

  // result word, read from the row before it shifts
  assign has_nxt = cursor_nxt < count_nxt;

  always_comb begin
    out_word_nxt.has_current = has_nxt;
    out_word_nxt.item_count  = cseqb_pkg::COUNT_W'(count_nxt);
    out_word_nxt.refused     = refused;
    if (!has_nxt) begin
      out_word_nxt.current_value = '0;
    end else if (placed) begin
      out_word_nxt.current_value = in_data.entry_value;
    end else begin
      out_word_nxt.current_value = cell_q[rd_idx[IDX_W-1:0]];
    end
  end

  // row of cells, each fed by both neighbors; the ends feed back on themselves
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    logic [cseqb_pkg::VALUE_W-1:0] left_q;
    logic [cseqb_pkg::VALUE_W-1:0] right_q;

    if (gi == 0) begin : g_first
      assign left_q = cell_q[gi];
    end else begin : g_mid_l
      assign left_q = cell_q[gi-1];
    end

    if (gi == DEPTH - 1) begin : g_last
      assign right_q = cell_q[gi];
    end else begin : g_mid_r
      assign right_q = cell_q[gi+1];
    end

    cseqb_cell #(
      .CELL_IDX (gi),
      .CNT_W    (CNT_W)
    ) u_cell (
      .clk     (clk),
      .ctrl    (cell_ctrl),
      .pos     (cell_pos),
      .left_q  (left_q),
      .right_q (right_q),
      .q       (cell_q[gi])
    );
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      cursor_r <= '0;
    end else if (accept) begin
      count_r  <= count_nxt;
      cursor_r <= cursor_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  // checks
  `CSB_ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, count_r <= DEPTH_C)
  `CSB_ASSERT_IMPLY(a_cursor_bound, clk, rst_n, 1'b1, cursor_r <= count_r)
  `CSB_ASSERT_NEXT(a_refuse_keeps, clk, rst_n, accept && refused,
                   (count_r == $past(count_r)) && (cursor_r == $past(cursor_r)))
  `CSB_ASSERT_NEXT(a_place_grows, clk, rst_n, accept && placed,
                   (count_r == $past(count_r) + ONE_C) && (cursor_r < count_r))

endmodule

`default_nettype wire

@@ bench/cursor_sequence_buffer_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cursor_sequence_buffer_top_tb
// self-checking bench for the cursor list buffer
// ----------------------------------------------------------------------------
// Words are offered in random bursts. Each accepted word runs through a local
// model of the list and cursor, and the model's report joins a queue. A
// separate process compares every result word with the oldest queued report,
// field by field. The receiver stalls on its own pattern. Once it holds off
// for a long stretch so that the buffer fills and in_ready drops. The tests
// cover the empty list, the cursor corner cases, a full list with refused
// edits, and a long run of random command sequences.
// ----------------------------------------------------------------------------

module cursor_sequence_buffer_top_tb;

  localparam int LIST_DEPTH = 32;

  // commands the buffer ignores
  localparam logic [cseqb_pkg::CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [cseqb_pkg::CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

  typedef enum int {BIAS_GROW, BIAS_SHRINK, BIAS_WALK} traffic_bias_t;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  cseqb_pkg::in_word_t  in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  cseqb_pkg::out_word_t out_data;

  // local copy of the list: values, count and cursor
  logic [cseqb_pkg::VALUE_W-1:0] list_values [LIST_DEPTH];
  int                            list_fill   = 0;
  int                            list_cursor = 0;

  // reports still owed by the buffer, oldest first
  cseqb_pkg::out_word_t reports_due [$];
  int                   mismatch_count = 0;

  // sender burst state
  int burst_left = 0;

  // receiver hold-off request, picked up by the receiver process
  int hold_request = 0;
  int hold_left    = 0;
  logic [7:0] stall_tick = '0;

  cursor_sequence_buffer_top #(
    .DEPTH(LIST_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // list model: apply one command, return the report it should produce
  // ---------------------------------------------------------------------------
  function automatic cseqb_pkg::out_word_t apply_list_command(input cseqb_pkg::in_word_t w);
    cseqb_pkg::out_word_t rep;
    logic                 had_current;
    int                   pos;
    rep         = '0;
    had_current = list_cursor < list_fill;
    pos         = 0;
    case (w.cmd)
      cseqb_pkg::CMD_START: begin
        list_cursor = 0;
      end
      cseqb_pkg::CMD_ADVANCE: begin
        if (had_current) list_cursor++;
        else rep.refused = 1'b1;
      end
      cseqb_pkg::CMD_INSERT, cseqb_pkg::CMD_ATTACH: begin
        if (list_fill >= LIST_DEPTH) begin
          rep.refused = 1'b1;
        end else begin
          // insert goes before the current entry or to the front,
          // attach goes after it or to the end
          if (w.cmd == cseqb_pkg::CMD_INSERT) pos = had_current ? list_cursor : 0;
          else pos = had_current ? list_cursor + 1 : list_fill;
          for (int i = list_fill; i > pos; i--) list_values[i] = list_values[i-1];
          list_values[pos] = w.entry_value;
          list_fill++;
          list_cursor = pos;
        end
      end
      cseqb_pkg::CMD_REMOVE: begin
        if (!had_current) begin
          rep.refused = 1'b1;
        end else begin
          // close the gap, the follower becomes current
          for (int i = list_cursor + 1; i < list_fill; i++) list_values[i-1] = list_values[i];
          list_fill--;
        end
      end
      default: begin
        // unused command codes leave everything alone
      end
    endcase
    if (list_cursor < list_fill) begin
      rep.current_value = list_values[list_cursor];
      rep.has_current   = 1'b1;
    end
    rep.item_count = list_fill[cseqb_pkg::COUNT_W-1:0];
    return rep;
  endfunction

  function automatic cseqb_pkg::in_word_t make_word(
      input logic [cseqb_pkg::CMD_W-1:0]   cmd,
      input logic [cseqb_pkg::VALUE_W-1:0] value);
    cseqb_pkg::in_word_t w;
    w.cmd         = cmd;
    w.entry_value = value;
    return w;
  endfunction

  // values lean toward the extremes now and then
  function automatic logic [cseqb_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return cseqb_pkg::VALUE_W'($urandom_range(0, 15));
      default: return cseqb_pkg::VALUE_W'($urandom);
    endcase
  endfunction

  function automatic logic [cseqb_pkg::CMD_W-1:0] pick_command(input traffic_bias_t bias);
    int roll;
    roll = $urandom_range(0, 99);
    case (bias)
      BIAS_GROW: begin
        if (roll < 35)      return cseqb_pkg::CMD_INSERT;
        else if (roll < 70) return cseqb_pkg::CMD_ATTACH;
        else if (roll < 85) return cseqb_pkg::CMD_ADVANCE;
        else if (roll < 92) return cseqb_pkg::CMD_START;
        else                return cseqb_pkg::CMD_REMOVE;
      end
      BIAS_SHRINK: begin
        if (roll < 45)      return cseqb_pkg::CMD_REMOVE;
        else if (roll < 60) return cseqb_pkg::CMD_INSERT;
        else if (roll < 70) return cseqb_pkg::CMD_ATTACH;
        else if (roll < 88) return cseqb_pkg::CMD_ADVANCE;
        else                return cseqb_pkg::CMD_START;
      end
      default: begin
        if (roll < 40)      return cseqb_pkg::CMD_ADVANCE;
        else if (roll < 55) return cseqb_pkg::CMD_START;
        else if (roll < 70) return cseqb_pkg::CMD_REMOVE;
        else if (roll < 85) return cseqb_pkg::CMD_INSERT;
        else                return cseqb_pkg::CMD_ATTACH;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // sender: offer one word and wait for its handshake
  // called at a rising edge; the next call or drain_reports must follow in
  // the same time step so in_valid never stays high on a stale word
  // ---------------------------------------------------------------------------
  task automatic offer_word(input cseqb_pkg::in_word_t w);
    int gap;
    if (burst_left == 0) begin
      // new burst: sometimes back to back, sometimes after a gap
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= w;
    // handshake is judged on the values seen just before the edge
    do @(posedge clk); while (!in_ready);
    reports_due.push_back(apply_list_command(w));
  endtask

  task automatic drain_reports();
    in_valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    // room for a stray extra result to show up
    repeat (8) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // receiver: stall pattern picked by the top bits of a tick counter, plus hold-offs
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      stall_tick++;
      case (stall_tick[7:6])
        2'd0:    out_ready <= 1'b1;
        2'd1:    out_ready <= 1'($urandom_range(0, 1));
        2'd2:    out_ready <= (stall_tick[1:0] != 2'd0);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // result checker: every accepted result word against the oldest report
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cseqb_pkg::out_word_t due;
    if (rst_n && out_valid && out_ready) begin
      if (reports_due.size() == 0) begin
        $error("result word with no report due: %h", out_data);
        mismatch_count++;
      end else begin
        due = reports_due.pop_front();
        if (out_data.current_value !== due.current_value) begin
          $error("current_value expected %h got %h", due.current_value,
                 out_data.current_value);
          mismatch_count++;
        end
        if (out_data.has_current !== due.has_current) begin
          $error("has_current expected %b got %b", due.has_current, out_data.has_current);
          mismatch_count++;
        end
        if (out_data.item_count !== due.item_count) begin
          $error("item_count expected %0d got %0d", due.item_count, out_data.item_count);
          mismatch_count++;
        end
        if (out_data.refused !== due.refused) begin
          $error("refused expected %b got %b", due.refused, out_data.refused);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // empty list: start, refused advance and remove, ignored codes
  task automatic test_empty_list();
    offer_word(make_word(cseqb_pkg::CMD_START, '1));
    offer_word(make_word(cseqb_pkg::CMD_ADVANCE, '0));
    offer_word(make_word(cseqb_pkg::CMD_REMOVE, '1));
    for (int c = CMD_UNUSED_LO; c <= CMD_UNUSED_HI; c++) begin
      offer_word(make_word(cseqb_pkg::CMD_W'(c), pick_value()));
    end
  endtask

  // cursor corners on a short list
  task automatic test_edit_corners();
    offer_word(make_word(cseqb_pkg::CMD_INSERT, '1));  // insert on empty goes to front
    offer_word(make_word(cseqb_pkg::CMD_ATTACH, '0));  // after current, becomes current
    offer_word(make_word(cseqb_pkg::CMD_ADVANCE, 32'h1234_5678)); // past the last entry
    offer_word(make_word(cseqb_pkg::CMD_ADVANCE, '0)); // no current, refused
    offer_word(make_word(cseqb_pkg::CMD_INSERT, 32'h8000_0001)); // no current, at front
    offer_word(make_word(cseqb_pkg::CMD_ADVANCE, '0));
    offer_word(make_word(cseqb_pkg::CMD_ADVANCE, '0));
    offer_word(make_word(cseqb_pkg::CMD_ADVANCE, '0));
    offer_word(make_word(cseqb_pkg::CMD_ATTACH, 32'h5a5a_a5a5)); // no current, at end
    offer_word(make_word(cseqb_pkg::CMD_REMOVE, '0));  // last entry, cursor left past end
    offer_word(make_word(cseqb_pkg::CMD_REMOVE, '0));  // refused
    offer_word(make_word(cseqb_pkg::CMD_START, '0));
    offer_word(make_word(cseqb_pkg::CMD_REMOVE, '1));  // follower becomes current
    offer_word(make_word(cseqb_pkg::CMD_ATTACH, 32'h7fff_fffe));
  endtask

  // fill to the brim, try edits on a full list, then empty it again
  task automatic test_fill_and_drain();
    while (list_fill < LIST_DEPTH) begin
      offer_word(make_word(($urandom_range(0, 1) != 0) ? cseqb_pkg::CMD_ATTACH
                                                       : cseqb_pkg::CMD_INSERT,
                           pick_value()));
    end
    offer_word(make_word(cseqb_pkg::CMD_INSERT, pick_value()));
    offer_word(make_word(cseqb_pkg::CMD_ATTACH, pick_value()));
    offer_word(make_word(cseqb_pkg::CMD_START, pick_value()));
    while (list_cursor < list_fill)
      offer_word(make_word(cseqb_pkg::CMD_ADVANCE, pick_value()));
    offer_word(make_word(cseqb_pkg::CMD_ATTACH, pick_value()));  // still full, refused
    offer_word(make_word(cseqb_pkg::CMD_START, '0));
    while (list_fill > 0) begin
      if ($urandom_range(0, 3) == 0 && list_cursor + 1 < list_fill)
        offer_word(make_word(cseqb_pkg::CMD_ADVANCE, pick_value()));
      else if (list_cursor >= list_fill)
        offer_word(make_word(cseqb_pkg::CMD_START, pick_value()));
      else
        offer_word(make_word(cseqb_pkg::CMD_REMOVE, pick_value()));
    end
  endtask

  // long receiver hold-off while words keep coming, so in_ready must drop
  task automatic test_output_hold_off();
    hold_request = 60;
    for (int n = 0; n < 16; n++) begin
      offer_word(make_word(pick_command(BIAS_GROW), pick_value()));
    end
  endtask

  // random command sequences in episodes that grow, shrink or walk the list
  task automatic test_random_traffic(input int word_goal);
    traffic_bias_t                 bias;
    int                            sent;
    int                            run;
    logic [cseqb_pkg::CMD_W-1:0]   cmd;
    sent = 0;
    while (sent < word_goal) begin
      case ($urandom_range(0, 2))
        0:       bias = BIAS_GROW;
        1:       bias = BIAS_SHRINK;
        default: bias = BIAS_WALK;
      endcase
      run = $urandom_range(5, 45);
      for (int n = 0; n < run; n++) begin
        if ($urandom_range(0, 99) < 3) begin
          // ignored codes, not counted toward the goal
          cmd = cseqb_pkg::CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        end else begin
          cmd = pick_command(bias);
          sent++;
        end
        offer_word(make_word(cmd, pick_value()));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_list();
    test_edit_corners();
    test_fill_and_drain();
    test_output_hold_off();
    test_random_traffic(350);
    drain_reports();

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
